// ===== rtl/pffla_pkg.sv =====
// pffla_pkg: shared types and constants of the page frame free list allocator
// holds status codes, request kinds and the controller to datapath command and status bundles
// no dependencies
package pffla_pkg;

    localparam int POOL_SIZE_DEF = 256;
    localparam int MAX_BURST_DEF = 64;

    localparam int COUNT_W  = 7;
    localparam int FRAME_W  = 8;
    localparam int STATUS_W = 2;
    localparam int LEFT_W   = 9;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic    clear_step;
        logic    latch;
        logic    free_ok;
        logic    emit_only;
        t_status code;
        logic    pop_start;
        logic    pop;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic req_free;
        logic free_bad;
        logic alloc_reject;
        logic alloc_zero;
        logic pop_last;
    } t_stat;

endpackage

// ===== rtl/pffla_ram.sv =====
// pffla_ram: generic single write, single read memory with registered read data
// read data holds while no read is issued
// no dependencies
module pffla_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pffla_dp.sv =====
// pffla_dp: datapath with link memory, head, free count, request and result registers
// depends on pffla_pkg and pffla_ram
module pffla_dp #(
    parameter int POOL_SIZE = pffla_pkg::POOL_SIZE_DEF,
    parameter int MAX_BURST = pffla_pkg::MAX_BURST_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pffla_pkg::t_cmd                i_cmd,
    output pffla_pkg::t_stat               o_stat,
    input  logic                           i_op,
    input  logic [pffla_pkg::COUNT_W-1:0]  i_count,
    input  logic [pffla_pkg::FRAME_W-1:0]  i_frame,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [pffla_pkg::FRAME_W-1:0]  o_frame_out,
    output logic                           o_frame_valid,
    output logic [pffla_pkg::STATUS_W-1:0] o_status,
    output logic                           o_last,
    output logic [pffla_pkg::LEFT_W-1:0]   o_free_left
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam int RW = $clog2(MAX_BURST + 1);
    localparam logic [LW-1:0] END_MARK = LW'(POOL_SIZE);

    logic [AW-1:0]                    r_clr_idx,    n_clr_idx;
    logic [LW-1:0]                    r_head,       n_head;
    logic [LW-1:0]                    r_free_count, n_free_count;
    logic [RW-1:0]                    r_remain,     n_remain;
    logic                             r_op;
    logic [pffla_pkg::COUNT_W-1:0]    r_count;
    logic [pffla_pkg::FRAME_W-1:0]    r_frame;

    logic                             r_out_valid,  n_out_valid;
    logic [pffla_pkg::FRAME_W-1:0]    r_out_frame,  n_out_frame;
    logic                             r_out_fvalid, n_out_fvalid;
    pffla_pkg::t_status               r_out_status, n_out_status;
    logic                             r_out_last,   n_out_last;
    logic [pffla_pkg::LEFT_W-1:0]     r_out_left,   n_out_left;

    logic [31:0]   frame_w;
    logic [31:0]   head_w;
    logic [31:0]   left_w;
    logic          head_ok;
    logic [LW-1:0] nxt;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [LW-1:0] ram_rdata;
    logic          emit;

    assign frame_w = 32'(r_frame);
    assign head_w  = 32'(r_head);
    assign head_ok = head_w < POOL_SIZE;
    assign nxt     = head_ok ? ram_rdata : END_MARK;

    assign o_stat.clear_done   = r_clr_idx == AW'(POOL_SIZE - 1);
    assign o_stat.out_free     = !r_out_valid || i_out_ready;
    assign o_stat.req_free     = r_op == pffla_pkg::OP_FREE;
    assign o_stat.free_bad     = (frame_w >= POOL_SIZE) || (32'(r_free_count) >= POOL_SIZE);
    assign o_stat.alloc_reject = (32'(r_count) > MAX_BURST) || (32'(r_count) > 32'(r_free_count));
    assign o_stat.alloc_zero   = r_count == '0;
    assign o_stat.pop_last     = r_remain == RW'(1);

    assign ram_we    = i_cmd.clear_step || i_cmd.free_ok;
    assign ram_waddr = i_cmd.clear_step ? r_clr_idx : AW'(frame_w);
    assign ram_wdata = i_cmd.clear_step ? LW'(32'(r_clr_idx) + 32'd1) : r_head;
    assign ram_re    = i_cmd.pop_start || i_cmd.pop;
    assign ram_raddr = i_cmd.pop ? AW'(nxt) : AW'(r_head);

    pffla_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SIZE)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign emit   = i_cmd.free_ok || i_cmd.emit_only || i_cmd.pop;
    assign left_w = 32'(n_free_count);

    always_comb begin
        n_clr_idx    = r_clr_idx;
        n_head       = r_head;
        n_free_count = r_free_count;
        n_remain     = r_remain;
        n_out_valid  = r_out_valid;
        n_out_frame  = r_out_frame;
        n_out_fvalid = r_out_fvalid;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;

        if (i_cmd.clear_step) begin
            n_clr_idx = r_clr_idx + AW'(1);
        end
        if (i_cmd.free_ok) begin
            n_head       = LW'(frame_w);
            n_free_count = r_free_count + LW'(1);
        end
        if (i_cmd.pop_start) begin
            n_remain = RW'(r_count);
        end
        if (i_cmd.pop) begin
            n_head       = nxt;
            n_free_count = r_free_count - LW'(1);
            n_remain     = r_remain - RW'(1);
        end

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_frame  = '0;
            n_out_fvalid = 1'b0;
            n_out_status = pffla_pkg::ST_OK;
            n_out_last   = 1'b1;
            if (i_cmd.emit_only) begin
                n_out_status = i_cmd.code;
            end
            if (i_cmd.pop) begin
                n_out_frame  = head_w[pffla_pkg::FRAME_W-1:0];
                n_out_fvalid = 1'b1;
                n_out_last   = r_remain == RW'(1);
            end
        end
        n_out_left = emit ? left_w[pffla_pkg::LEFT_W-1:0] : r_out_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx    <= '0;
            r_head       <= '0;
            r_free_count <= LW'(POOL_SIZE);
            r_remain     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_clr_idx    <= n_clr_idx;
            r_head       <= n_head;
            r_free_count <= n_free_count;
            r_remain     <= n_remain;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_op;
            r_count <= i_count;
            r_frame <= i_frame;
        end
        r_out_frame  <= n_out_frame;
        r_out_fvalid <= n_out_fvalid;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_left   <= n_out_left;
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_out   = r_out_frame;
    assign o_frame_valid = r_out_fvalid;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;
    assign o_free_left   = r_out_left;

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free_count) <= POOL_SIZE)
        else $error("free count above pool size");

    a_pop_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_remain != '0)
        else $error("pop with no frames left in the burst");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !emit)
        else $error("result register overwritten while stalled");

    a_pop_takes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> r_free_count == $past(r_free_count) - LW'(1))
        else $error("pop did not take exactly one frame");
`endif

endmodule

// ===== rtl/pffla_ctrl.sv =====
// pffla_ctrl: controller state machine of the allocator
// sequences the clearing pass, request capture, free, reject, zero-count and pop steps; depends on pffla_pkg
module pffla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pffla_pkg::t_stat i_stat,
    output pffla_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_POP   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.code      = pffla_pkg::ST_OK;
        o_in_ready      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                    if (i_stat.req_free) begin
                        if (i_stat.free_bad) begin
                            o_cmd.emit_only = 1'b1;
                            o_cmd.code      = pffla_pkg::ST_BADFREE;
                        end else begin
                            o_cmd.free_ok = 1'b1;
                        end
                    end else if (i_stat.alloc_reject) begin
                        o_cmd.emit_only = 1'b1;
                        o_cmd.code      = pffla_pkg::ST_NOSPACE;
                    end else if (i_stat.alloc_zero) begin
                        o_cmd.emit_only = 1'b1;
                    end else begin
                        o_cmd.pop_start = 1'b1;
                        n_state         = S_POP;
                    end
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.pop_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !$past(o_cmd.latch))
        else $error("request taken on two consecutive cycles");

    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pop || o_cmd.free_ok || o_cmd.emit_only) |-> i_stat.out_free)
        else $error("result issued with no room in the result register");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clear_step, o_cmd.latch, o_cmd.free_ok, o_cmd.emit_only,
                  o_cmd.pop_start, o_cmd.pop}))
        else $error("more than one datapath action at once");
`endif

endmodule

// ===== rtl/page_frame_free_list_allocator.sv =====
// page_frame_free_list_allocator: free list page frame allocator, top level
// a free or a rejected request goes from the request registers to the result register once that has room,
// and only then is the next request accepted; an allocate of n frames reads the link of the head first, then
// gives one frame a cycle while the result register has room (one link memory read per frame), and accepts
// no new request until its last frame is issued; after reset a clearing pass over every entry rebuilds the link
// memory, input not ready; depends on pffla_pkg, pffla_ctrl, pffla_dp
module page_frame_free_list_allocator #(
    parameter int POOL_SIZE = pffla_pkg::POOL_SIZE_DEF,
    parameter int MAX_BURST = pffla_pkg::MAX_BURST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // count[6:0], frame_in[14:7], zero pad
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // frame_out[7:0], status[9:8], free_left[18:10], zero pad
    output logic        m_axis_tuser,   // frame_valid
    output logic        m_axis_tlast
);

    pffla_pkg::t_cmd                cmd;
    pffla_pkg::t_stat               stat;
    logic [pffla_pkg::FRAME_W-1:0]  frame_out;
    logic [pffla_pkg::STATUS_W-1:0] status;
    logic [pffla_pkg::LEFT_W-1:0]   free_left;

    pffla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pffla_dp #(
        .POOL_SIZE (POOL_SIZE),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (s_axis_tuser),
        .i_count       (s_axis_tdata[6:0]),
        .i_frame       (s_axis_tdata[14:7]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_frame_out   (frame_out),
        .o_frame_valid (m_axis_tuser),
        .o_status      (status),
        .o_last        (m_axis_tlast),
        .o_free_left   (free_left)
    );

    assign m_axis_tdata = {5'd0, free_left, status, frame_out};

endmodule
